// ===== sv/ttuc_pkg.sv =====
// ttuc_pkg: shared types, codes and the control store of the task table checker
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps

package ttuc_pkg;

   // field widths of the request and response beats
   localparam int OP_W     = 2;
   localparam int ID_W     = 8;
   localparam int TICK_W   = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int UTIL_W   = 24;
   localparam int QUOT_W   = 32;

   // op codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INFEASIBLE = 2'd3;

   // utilization constants, unsigned q8.16
   localparam logic [UTIL_W-1:0] Q_ONE    = 24'h010000;
   localparam logic [UTIL_W-1:0] UTIL_MAX = 24'hFFFFFF;

   // one table slot
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] run_ticks;
   } slot_type;

   // jump conditions of the sequencer
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_BEAT,
      COND_OP_CHECK,
      COND_OP_UNUSED,
      COND_MATCH,
      COND_NOT_LAST,
      COND_EMPTY,
      COND_ZERO,
      COND_BUSY,
      COND_RSP_WAIT
   } cond_type;

   // datapath actions of the sequencer
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_INC,
      ACT_MISS,
      ACT_START,
      ACT_ACCUM,
      ACT_DONE,
      ACT_WRITE,
      ACT_IMPOSSIBLE,
      ACT_RESPOND
   } act_type;

   localparam int UPC_W = 5;

   typedef struct packed {
      cond_type         cond;
      logic [UPC_W-1:0] target;
      act_type          act;
   } ucode_type;

   // control store addresses
   localparam logic [UPC_W-1:0] UA_IDLE       = 5'd0;
   localparam logic [UPC_W-1:0] UA_DISPATCH   = 5'd1;
   localparam logic [UPC_W-1:0] UA_DISPATCH2  = 5'd2;
   localparam logic [UPC_W-1:0] UA_FIND_READ  = 5'd3;
   localparam logic [UPC_W-1:0] UA_FIND_CMP   = 5'd4;
   localparam logic [UPC_W-1:0] UA_FIND_NEXT  = 5'd5;
   localparam logic [UPC_W-1:0] UA_FIND_MISS  = 5'd6;
   localparam logic [UPC_W-1:0] UA_CHK_READ   = 5'd7;
   localparam logic [UPC_W-1:0] UA_CHK_EMPTY  = 5'd8;
   localparam logic [UPC_W-1:0] UA_CHK_ZERO   = 5'd9;
   localparam logic [UPC_W-1:0] UA_CHK_START  = 5'd10;
   localparam logic [UPC_W-1:0] UA_CHK_WAIT   = 5'd11;
   localparam logic [UPC_W-1:0] UA_CHK_ACCUM  = 5'd12;
   localparam logic [UPC_W-1:0] UA_CHK_NEXT   = 5'd13;
   localparam logic [UPC_W-1:0] UA_CHK_DONE   = 5'd14;
   localparam logic [UPC_W-1:0] UA_WRITE      = 5'd15;
   localparam logic [UPC_W-1:0] UA_IMPOSSIBLE = 5'd16;
   localparam logic [UPC_W-1:0] UA_RESPOND    = 5'd17;
   localparam logic [UPC_W-1:0] UA_RETURN     = 5'd18;

   // control store: a true condition jumps to target, otherwise fall through
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] upc);
      ucode_type w;
      unique case (upc)
         UA_IDLE:       w = '{COND_NO_BEAT,   UA_IDLE,       ACT_ACCEPT};
         UA_DISPATCH:   w = '{COND_OP_CHECK,  UA_CHK_READ,   ACT_NONE};
         UA_DISPATCH2:  w = '{COND_OP_UNUSED, UA_RESPOND,    ACT_NONE};
         UA_FIND_READ:  w = '{COND_NEVER,     UA_IDLE,       ACT_NONE};
         UA_FIND_CMP:   w = '{COND_MATCH,     UA_WRITE,      ACT_NONE};
         UA_FIND_NEXT:  w = '{COND_NOT_LAST,  UA_FIND_READ,  ACT_INC};
         UA_FIND_MISS:  w = '{COND_ALWAYS,    UA_RESPOND,    ACT_MISS};
         UA_CHK_READ:   w = '{COND_NEVER,     UA_IDLE,       ACT_NONE};
         UA_CHK_EMPTY:  w = '{COND_EMPTY,     UA_CHK_NEXT,   ACT_NONE};
         UA_CHK_ZERO:   w = '{COND_ZERO,      UA_IMPOSSIBLE, ACT_NONE};
         UA_CHK_START:  w = '{COND_NEVER,     UA_IDLE,       ACT_START};
         UA_CHK_WAIT:   w = '{COND_BUSY,      UA_CHK_WAIT,   ACT_NONE};
         UA_CHK_ACCUM:  w = '{COND_NEVER,     UA_IDLE,       ACT_ACCUM};
         UA_CHK_NEXT:   w = '{COND_NOT_LAST,  UA_CHK_READ,   ACT_INC};
         UA_CHK_DONE:   w = '{COND_ALWAYS,    UA_RESPOND,    ACT_DONE};
         UA_WRITE:      w = '{COND_ALWAYS,    UA_RESPOND,    ACT_WRITE};
         UA_IMPOSSIBLE: w = '{COND_NEVER,     UA_IDLE,       ACT_IMPOSSIBLE};
         UA_RESPOND:    w = '{COND_RSP_WAIT,  UA_RESPOND,    ACT_RESPOND};
         UA_RETURN:     w = '{COND_ALWAYS,    UA_IDLE,       ACT_NONE};
         default:       w = '{COND_ALWAYS,    UA_IDLE,       ACT_NONE};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/ttuc_ifs.sv =====
// ttuc_req_if, ttuc_rsp_if: valid/ready channels for request and response beats
// depends on ttuc_pkg for field widths
`timescale 1ns / 1ps

interface ttuc_req_if;
   logic                         valid;
   logic                         ready;
   logic [ttuc_pkg::OP_W-1:0]    op;
   logic [ttuc_pkg::ID_W-1:0]    task_id;
   logic [ttuc_pkg::TICK_W-1:0]  period;
   logic [ttuc_pkg::TICK_W-1:0]  run_ticks;

   modport source (output valid, output op, output task_id, output period,
                   output run_ticks, input ready);
   modport sink (input valid, input op, input task_id, input period,
                 input run_ticks, output ready);
endinterface

interface ttuc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ttuc_pkg::STATUS_W-1:0] status;
   logic [ttuc_pkg::SLOT_W-1:0]   slot_index;
   logic [ttuc_pkg::UTIL_W-1:0]   utilization;

   modport source (output valid, output status, output slot_index,
                   output utilization, input ready);
   modport sink (input valid, input status, input slot_index,
                 input utilization, output ready);
endinterface

// ===== sv/ttuc_divider.sv =====
// ttuc_divider: radix-4 restoring divider, (run_ticks << 16) / period
// depends on ttuc_pkg; busy while running
`timescale 1ns / 1ps

module ttuc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttuc_pkg::TICK_W-1:0]   dividend_hi,
   input  logic [ttuc_pkg::TICK_W-1:0]   divisor,
   output logic                          busy,
   output logic [ttuc_pkg::QUOT_W-1:0]   quotient
);

   logic                          busy_ff, busy_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic [ttuc_pkg::QUOT_W-1:0]   dq_ff, dq_in;
   logic [ttuc_pkg::TICK_W-1:0]   rem_ff, rem_in;
   logic [ttuc_pkg::TICK_W-1:0]   div_ff, div_in;
   logic [ttuc_pkg::TICK_W:0]     part1, part2, diff1, diff2;
   logic                          ge1, ge2;

   // two dependent compare and subtract steps per cycle
   always_comb begin
      part1 = {rem_ff, dq_ff[ttuc_pkg::QUOT_W-1]};
      ge1   = part1 >= {1'b0, div_ff};
      diff1 = ge1 ? (part1 - {1'b0, div_ff}) : part1;
      part2 = {diff1[ttuc_pkg::TICK_W-1:0], dq_ff[ttuc_pkg::QUOT_W-2]};
      ge2   = part2 >= {1'b0, div_ff};
      diff2 = ge2 ? (part2 - {1'b0, div_ff}) : part2;
   end

   // load on start, then shift quotient bits in from the bottom
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = {dividend_hi, {ttuc_pkg::TICK_W{1'b0}}};
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[ttuc_pkg::QUOT_W-3:0], ge1, ge2};
         rem_in = diff2[ttuc_pkg::TICK_W-1:0];
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff;

endmodule

// ===== sv/task_table_utilization_check.sv =====
// Periodic task table with an EDF utilization admission test. Add writes a task to the
// lowest empty slot, remove clears the lowest slot whose id matches, and check sums
// run_ticks/period over occupied slots in saturating unsigned q8.16. A microcoded
// sequencer walks the table one slot at a time through a single-port slot memory with
// a registered read. Check hands each occupied slot to the shared divider, which
// produces two quotient bits per cycle, and a task with zero period or run time ends
// the walk early. One item is in work at a time; the response register holds until
// its beat is taken, and a stalled response stalls the request side.
// depends on ttuc_pkg, ttuc_ifs and ttuc_divider
`timescale 1ns / 1ps

module task_table_utilization_check #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   ttuc_req_if.sink      req_bus,
   ttuc_rsp_if.source    rsp_bus
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

   // sequencer and request registers
   logic [ttuc_pkg::UPC_W-1:0]    upc_ff, upc_in;
   logic [ttuc_pkg::OP_W-1:0]     op_ff, op_in;
   logic [ttuc_pkg::ID_W-1:0]     key_ff, key_in;
   logic [ttuc_pkg::ID_W-1:0]     id_ff, id_in;
   logic [ttuc_pkg::TICK_W-1:0]   per_ff, per_in;
   logic [ttuc_pkg::TICK_W-1:0]   ex_ff, ex_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [ttuc_pkg::UTIL_W-1:0]   sum_ff, sum_in;
   logic [ttuc_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ttuc_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [ttuc_pkg::UTIL_W-1:0]   util_ff, util_in;
   logic [TABLE_SLOTS-1:0]        vld_ff, vld_in;

   // slot memory and its registered read
   ttuc_pkg::slot_type            slot_mem [TABLE_SLOTS];
   ttuc_pkg::slot_type            rd_ff;
   logic                          rd_vld_ff;
   ttuc_pkg::slot_type            entry;
   ttuc_pkg::slot_type            wr_data;
   logic                          wr_en;

   ttuc_pkg::ucode_type           uw;
   logic                          cond_true;
   logic                          div_start;
   logic                          div_busy;
   logic [ttuc_pkg::QUOT_W-1:0]   div_quot;
   logic [ttuc_pkg::QUOT_W:0]     acc;

   assign uw       = ttuc_pkg::ucode_rom(upc_ff);
   assign entry    = rd_vld_ff ? rd_ff : '0;

   // condition select
   always_comb begin
      unique case (uw.cond)
         ttuc_pkg::COND_NEVER:     cond_true = 1'b0;
         ttuc_pkg::COND_ALWAYS:    cond_true = 1'b1;
         ttuc_pkg::COND_NO_BEAT:   cond_true = !req_bus.valid;
         ttuc_pkg::COND_OP_CHECK:  cond_true = op_ff == ttuc_pkg::OP_CHECK;
         ttuc_pkg::COND_OP_UNUSED: cond_true = op_ff == ttuc_pkg::OP_UNUSED;
         ttuc_pkg::COND_MATCH:     cond_true = entry.id == key_ff;
         ttuc_pkg::COND_NOT_LAST:  cond_true = idx_ff != IDX_LAST;
         ttuc_pkg::COND_EMPTY:     cond_true = entry.id == '0;
         ttuc_pkg::COND_ZERO:      cond_true = (entry.period == '0) ||
                                               (entry.run_ticks == '0);
         ttuc_pkg::COND_BUSY:      cond_true = div_busy;
         ttuc_pkg::COND_RSP_WAIT:  cond_true = !rsp_bus.ready;
         default:                  cond_true = 1'b0;
      endcase
   end

   // saturating accumulate of one quotient
   assign acc = {{(ttuc_pkg::QUOT_W + 1 - ttuc_pkg::UTIL_W){1'b0}}, sum_ff}
                + {1'b0, div_quot};

   // step counter and datapath actions
   always_comb begin
      upc_in    = cond_true ? uw.target : (upc_ff + 1'b1);
      op_in     = op_ff;
      key_in    = key_ff;
      id_in     = id_ff;
      per_in    = per_ff;
      ex_in     = ex_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      util_in   = util_ff;
      vld_in    = vld_ff;
      wr_en     = 1'b0;
      wr_data   = '0;
      div_start = 1'b0;
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;

      case (uw.act)
         ttuc_pkg::ACT_ACCEPT: begin
            // no request beat is taken while reset is held
            req_bus.ready = !reset;
            if (req_bus.valid && !reset) begin
               op_in     = req_bus.op;
               key_in    = (req_bus.op == ttuc_pkg::OP_ADD) ? '0 : req_bus.task_id;
               id_in     = req_bus.task_id;
               per_in    = req_bus.period;
               ex_in     = req_bus.run_ticks;
               idx_in    = '0;
               sum_in    = '0;
               status_in = ttuc_pkg::ST_OK;
               slot_in   = '0;
               util_in   = '0;
            end
         end
         ttuc_pkg::ACT_INC: begin
            idx_in = idx_ff + 1'b1;
         end
         ttuc_pkg::ACT_MISS: begin
            status_in = (op_ff == ttuc_pkg::OP_ADD) ? ttuc_pkg::ST_FULL
                                                    : ttuc_pkg::ST_NOT_FOUND;
         end
         ttuc_pkg::ACT_START: begin
            div_start = 1'b1;
         end
         ttuc_pkg::ACT_ACCUM: begin
            if (acc > {{(ttuc_pkg::QUOT_W + 1 - ttuc_pkg::UTIL_W){1'b0}},
                       ttuc_pkg::UTIL_MAX}) begin
               sum_in = ttuc_pkg::UTIL_MAX;
            end else begin
               sum_in = acc[ttuc_pkg::UTIL_W-1:0];
            end
         end
         ttuc_pkg::ACT_DONE: begin
            util_in   = sum_ff;
            status_in = (sum_ff >= ttuc_pkg::Q_ONE) ? ttuc_pkg::ST_INFEASIBLE
                                                    : ttuc_pkg::ST_OK;
         end
         ttuc_pkg::ACT_WRITE: begin
            wr_en          = 1'b1;
            vld_in[idx_ff] = 1'b1;
            if (op_ff == ttuc_pkg::OP_ADD) begin
               wr_data = '{id: id_ff, period: per_ff, run_ticks: ex_ff};
            end
            status_in = ttuc_pkg::ST_OK;
            slot_in   = ttuc_pkg::SLOT_W'(idx_ff);
         end
         ttuc_pkg::ACT_IMPOSSIBLE: begin
            util_in   = ttuc_pkg::Q_ONE;
            status_in = ttuc_pkg::ST_INFEASIBLE;
         end
         ttuc_pkg::ACT_RESPOND: begin
            rsp_bus.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff    <= ttuc_pkg::UA_IDLE;
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         upc_ff    <= upc_in;
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[idx_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      id_ff     <= id_in;
      per_ff    <= per_in;
      ex_ff     <= ex_in;
      idx_ff    <= idx_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      util_ff   <= util_in;
   end

   // slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[idx_ff] <= wr_data;
      end
      rd_ff <= slot_mem[idx_ff];
   end

   ttuc_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi (entry.run_ticks),
      .divisor     (entry.period),
      .busy        (div_busy),
      .quotient    (div_quot)
   );

   // response beat
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.slot_index  = slot_ff;
   assign rsp_bus.utilization = util_ff;

endmodule
